/* rtl/alid_pkg.sv */
// shared types and constants for the array list insert/delete core
package alid_pkg;

  // list store depth
  localparam int unsigned CAPACITY = 128;

  // store address width and entry count width
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MOVES_W = 7;
  localparam int unsigned LEN_W   = 8;

  // width used to compare positions against the entry count
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_RUN   = 2'd1,
    S_DRAIN = 2'd2,
    S_DONE  = 2'd3
  } state_e;

endpackage

/* rtl/array_list_insert_delete_core.sv */
// ordered list of signed words in a single memory, with insert, delete, read and clear
//
// An ordered list of up to alid_pkg::CAPACITY signed 32-bit words. A command is
// taken at a clock edge with start high and busy low; exactly one result beat
// follows, shown for one cycle with result_valid_o high, and the receiver cannot
// hold it off. Insert at position p (0 to length) shifts the later entries up,
// delete at p returns the entry and shifts the later entries down, read returns
// one entry, clear empties the list. A result carries data, status (ok, full,
// bad position), the number of entries shifted and the new length. Entries move
// one per cycle through the memory's single read port and single write port,
// with the read and the write of neighboring entries overlapped. A command that
// moves or reads entries steps through a run state, which reads one entry per
// cycle, a drain state and a done state; a clear, a rejected command or an
// insert that shifts nothing goes straight to the done state. The result beat
// is shown in the done state, and the block then returns to idle. The memory
// needs no clearing after reset: only entries below the length are ever read.
module array_list_insert_delete_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             opcode_i,
  input  logic [alid_pkg::POS_W-1:0]             position_i,
  input  logic signed [alid_pkg::DATA_W-1:0]     value_i,
  output logic                                   result_valid_o,
  output logic signed [alid_pkg::DATA_W-1:0]     data_o,
  output logic [1:0]                             status_o,
  output logic [alid_pkg::MOVES_W-1:0]           moves_o,
  output logic [alid_pkg::LEN_W-1:0]             length_o
);

  // list store
  logic [alid_pkg::DATA_W-1:0] mem [alid_pkg::CAPACITY];
  logic [alid_pkg::DATA_W-1:0] rdata_q;

  // sequencer state
  alid_pkg::state_e             state_q, state_d;
  alid_pkg::opcode_e            op_q, op_d;
  alid_pkg::status_e            status_q, status_d;
  logic [alid_pkg::CW-1:0]      count_q, count_d;
  logic [alid_pkg::AW-1:0]      ptr_q, ptr_d;       // next read address
  logic [alid_pkg::AW-1:0]      end_q, end_d;       // last read address
  logic [alid_pkg::AW-1:0]      pos_q, pos_d;
  logic [alid_pkg::AW-1:0]      raddr_q, raddr_d;   // address of the read in flight
  logic                         rvalid_q, rvalid_d; // rdata_q holds a fresh entry
  logic [alid_pkg::DATA_W-1:0]  val_q, val_d;
  logic [alid_pkg::DATA_W-1:0]  data_q, data_d;
  logic [alid_pkg::MOVES_W-1:0] moves_q, moves_d;

  // memory port controls
  logic                         mem_re;
  logic [alid_pkg::AW-1:0]      mem_ra;
  logic                         mem_we;
  logic [alid_pkg::AW-1:0]      mem_wa;
  logic [alid_pkg::DATA_W-1:0]  mem_wd;

  // command decode helpers
  logic                         accept;
  logic [alid_pkg::CMPW-1:0]    cnt_x;
  logic [alid_pkg::CMPW-1:0]    pos_x;
  logic [alid_pkg::CMPW-1:0]    ins_span;
  logic [alid_pkg::CMPW-1:0]    del_span;
  logic [alid_pkg::CMPW-1:0]    last_x;

  assign accept   = start && (state_q == alid_pkg::S_IDLE);
  assign busy     = (state_q != alid_pkg::S_IDLE);
  assign cnt_x    = alid_pkg::CMPW'(count_q);
  assign pos_x    = alid_pkg::CMPW'(position_i);
  assign ins_span = cnt_x - pos_x;            // entries shifted by an insert
  assign last_x   = cnt_x - 1'b1;             // index of the last entry
  assign del_span = last_x - pos_x;           // entries shifted by a delete

  // result beat straight from registers
  assign result_valid_o = (state_q == alid_pkg::S_DONE);
  assign data_o         = data_q;
  assign status_o       = status_q;
  assign moves_o        = moves_q;
  assign length_o       = alid_pkg::LEN_W'(count_q);

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= alid_pkg::S_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  // payload and pointer registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    pos_q    <= pos_d;
    raddr_q  <= raddr_d;
    val_q    <= val_d;
    data_q   <= data_d;
    moves_q  <= moves_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    pos_d    = pos_q;
    raddr_d  = raddr_q;
    rvalid_d = 1'b0;
    val_d    = val_q;
    data_d   = data_q;
    moves_d  = moves_q;
    mem_re   = 1'b0;
    mem_ra   = ptr_q;
    mem_we   = 1'b0;
    mem_wa   = pos_q;
    mem_wd   = val_q;

    // entry returned by last cycle's read: move it or capture it
    if (rvalid_q) begin
      unique case (op_q)
        alid_pkg::OP_INSERT: begin
          mem_we = 1'b1;
          mem_wa = alid_pkg::AW'(raddr_q + 1'b1);
          mem_wd = rdata_q;
        end
        alid_pkg::OP_DELETE: begin
          if (raddr_q == pos_q) begin
            data_d = rdata_q;
          end else begin
            mem_we = 1'b1;
            mem_wa = alid_pkg::AW'(raddr_q - 1'b1);
            mem_wd = rdata_q;
          end
        end
        alid_pkg::OP_READ: begin
          data_d = rdata_q;
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      alid_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = alid_pkg::opcode_e'(opcode_i);
          val_d    = value_i;
          pos_d    = position_i[alid_pkg::AW-1:0];
          data_d   = '0;
          moves_d  = '0;
          status_d = alid_pkg::ST_OK;
          state_d  = alid_pkg::S_DONE;
          unique case (alid_pkg::opcode_e'(opcode_i))
            alid_pkg::OP_INSERT: begin
              if (count_q == alid_pkg::CW'(alid_pkg::CAPACITY)) begin
                status_d = alid_pkg::ST_FULL;
              end else if (pos_x > cnt_x) begin
                status_d = alid_pkg::ST_BADPOS;
              end else begin
                moves_d = ins_span[alid_pkg::MOVES_W-1:0];
                count_d = count_q + 1'b1;
                ptr_d   = last_x[alid_pkg::AW-1:0];
                end_d   = pos_x[alid_pkg::AW-1:0];
                if (ins_span != '0) begin
                  state_d = alid_pkg::S_RUN;
                end
              end
            end
            alid_pkg::OP_DELETE: begin
              if (pos_x >= cnt_x) begin
                status_d = alid_pkg::ST_BADPOS;
              end else begin
                moves_d = del_span[alid_pkg::MOVES_W-1:0];
                count_d = count_q - 1'b1;
                ptr_d   = pos_x[alid_pkg::AW-1:0];
                end_d   = last_x[alid_pkg::AW-1:0];
                state_d = alid_pkg::S_RUN;
              end
            end
            alid_pkg::OP_READ: begin
              if (pos_x >= cnt_x) begin
                status_d = alid_pkg::ST_BADPOS;
              end else begin
                ptr_d   = pos_x[alid_pkg::AW-1:0];
                end_d   = pos_x[alid_pkg::AW-1:0];
                state_d = alid_pkg::S_RUN;
              end
            end
            alid_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      alid_pkg::S_RUN: begin
        // one read per cycle, walking toward end_q
        mem_re   = 1'b1;
        mem_ra   = ptr_q;
        rvalid_d = 1'b1;
        raddr_d  = ptr_q;
        if (ptr_q == end_q) begin
          state_d = alid_pkg::S_DRAIN;
        end else if (op_q == alid_pkg::OP_INSERT) begin
          ptr_d = ptr_q - 1'b1;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      alid_pkg::S_DRAIN: begin
        // last returned entry is handled above
        state_d = alid_pkg::S_DONE;
      end
      alid_pkg::S_DONE: begin
        // an insert drops the new word into the opened slot
        if (op_q == alid_pkg::OP_INSERT && status_q == alid_pkg::ST_OK) begin
          mem_we = 1'b1;
          mem_wa = pos_q;
          mem_wd = val_q;
        end
        state_d = alid_pkg::S_IDLE;
      end
      default: begin
        state_d = alid_pkg::S_IDLE;
      end
    endcase
  end

  // the result beat lasts exactly one cycle
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat longer than one cycle");

  // an accepted command keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after accepting a command");

  // entry count never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= alid_pkg::CW'(alid_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // overlapped shift never writes the entry being read
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("shift writes the address it reads");

  // rejected commands return no data and move nothing
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != alid_pkg::ST_OK) |-> (data_o == '0 && moves_o == '0))
    else $error("rejected command reports data or moves");

endmodule
